FILE: hdl/fsrl_pkg.sv
`timescale 1ns / 1ps
package fsrl_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_LABELS     = 16384;
  localparam int MEAN_FRAC_BITS = 4;

  localparam int CH_W       = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LABEL_W    = $clog2(MAX_LABELS);
  localparam int MEAN_W     = CH_W + MEAN_FRAC_BITS;
  localparam int COUNT_W    = 21;
  localparam int THR_W      = 18;
  localparam int FW_W       = 11;
  localparam int SQ_W       = 2 * MEAN_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int LIM_W      = THR_W + 2 * MEAN_FRAC_BITS;
  localparam int CMP_W      = (DIST_W > LIM_W) ? DIST_W : LIM_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [CH_W-1:0]    pix_t;
  typedef logic [MEAN_W-1:0]  mean_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [CMP_W-1:0]   cmp_t;
  typedef logic [FW_W-1:0]    fw_t;
  typedef logic [THR_W-1:0]   thr_t;

  localparam label_t LABEL_MAX = label_t'(MAX_LABELS - 1);
  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    mean_t r;
    mean_t g;
    mean_t b;
  } means_t;

  typedef struct packed {
    logic   valid;
    label_t lab;
  } link_t;

  typedef struct packed {
    logic   cmd;
    logic   frame_start;
    pix_t   red;
    pix_t   green;
    pix_t   blue;
    label_t query_label;
  } in_item_t;

  typedef struct packed {
    label_t label;
    count_t region_size;
    logic   overflow;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 1'b0,
    CFG_FRAME_WIDTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_LRD, S_LCHK, S_TST, S_ML, S_MT, S_NL, S_NT,
    S_ACT, S_MRG2, S_QRD, S_QSZ, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_L, PH_T, PH_Q
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_QOOR, OP_INIT0, OP_RES_L, OP_RES_T, OP_RES_Q,
    OP_LINK_RD, OP_STEP, OP_ROOT_L, OP_ROOT_T, OP_ROOT_Q, OP_MRD_L,
    OP_MRD_T, OP_CAP_T, OP_NEAR_T, OP_ACT, OP_CLR_T, OP_QSZ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic q_oor;
    logic first_pix;
    logic two_nbr;
    logic link_valid;
    logic merge;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/fsrl_if.sv
`timescale 1ns / 1ps
interface fsrl_in_if import fsrl_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  logic   frame_start;
  pix_t   red;
  pix_t   green;
  pix_t   blue;
  label_t query_label;

  modport source (output valid, cmd, frame_start, red, green, blue, query_label,
                  input ready);
  modport sink (input valid, cmd, frame_start, red, green, blue, query_label,
                output ready);
endinterface

interface fsrl_out_if import fsrl_pkg::*; ();
  logic   valid;
  logic   ready;
  label_t label;
  count_t region_size;
  logic   overflow;

  modport source (output valid, label, region_size, overflow, input ready);
  modport sink (input valid, label, region_size, overflow, output ready);
endinterface

FILE: hdl/fast_scan_region_labeler.sv
`timescale 1ns / 1ps
// Region labeler for RGB pixels streamed in raster order.
// in_if: valid/ready channel; cmd 0 is a pixel, cmd 1 resolves query_label
// to its root label. out_if: one result per input item, in order: label,
// region_size and overflow. cfg_*: write threshold (index 0) or frame_width
// (index 1) while the block is idle; no read-back.
// One item is worked on at a time; in_if.ready is high only between items.
// The first pixel of a frame and a query above the highest label go
// straight to the output state; other items walk the label table, and
// each link walked takes a read state (S_LRD) and a check state (S_LCHK).
// A pixel with two neighbors walks the table twice, once per neighbor.
// The label-link memory has a single read port.
// The next item is taken the cycle after its result is loaded into the
// output register.
// Reset restores threshold 400 and frame_width 640 and acts as a frame
// start; table contents are not cleared. When the receiver stalls, the
// result holds in the output register and the next item may already be
// taken, but its result waits until the register frees.
module fast_scan_region_labeler import fsrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fsrl_in_if.sink               in_if,
  fsrl_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  assign in_item = '{cmd: in_if.cmd, frame_start: in_if.frame_start, red: in_if.red,
                     green: in_if.green, blue: in_if.blue,
                     query_label: in_if.query_label};
  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.label       = out_item.label;
  assign out_if.region_size = out_item.region_size;
  assign out_if.overflow    = out_item.overflow;

  fsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsrl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second item taken while one is in work");

  a_ovf_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.overflow |-> out_if.label == LABEL_MAX)
    else $error("overflow result without last label");

  a_ovf_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.overflow |-> out_if.region_size == count_t'(1))
    else $error("overflow result with region size other than one");
`endif

endmodule

FILE: hdl/fsrl_ctrl.sv
`timescale 1ns / 1ps
module fsrl_ctrl import fsrl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_L;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_query) begin
          if (stat.q_oor) begin
            cmd.op    = OP_QOOR;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = OP_RES_Q;
            phase_nxt = PH_Q;
            state_nxt = S_LRD;
          end
        end else if (stat.first_pix) begin
          cmd.op    = OP_INIT0;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_RES_L;
          phase_nxt = PH_L;
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        cmd.op    = OP_LINK_RD;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (stat.link_valid) begin
          cmd.op    = OP_STEP;
          state_nxt = S_LRD;
        end else begin
          case (phase_r)
            PH_L: begin
              cmd.op    = OP_ROOT_L;
              state_nxt = stat.two_nbr ? S_TST : S_ML;
            end
            PH_T: begin
              cmd.op    = OP_ROOT_T;
              state_nxt = S_ML;
            end
            PH_Q: begin
              cmd.op    = OP_ROOT_Q;
              state_nxt = S_QRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TST: begin
        cmd.op    = OP_RES_T;
        phase_nxt = PH_T;
        state_nxt = S_LRD;
      end
      S_ML: begin
        cmd.op    = OP_MRD_L;
        state_nxt = S_MT;
      end
      S_MT: begin
        cmd.op    = OP_MRD_T;
        state_nxt = S_NL;
      end
      S_NL: begin
        cmd.op    = OP_CAP_T;
        state_nxt = S_NT;
      end
      S_NT: begin
        cmd.op    = OP_NEAR_T;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        cmd.op    = OP_ACT;
        state_nxt = stat.merge ? S_MRG2 : S_OUT;
      end
      S_MRG2: begin
        cmd.op    = OP_CLR_T;
        state_nxt = S_OUT;
      end
      S_QRD: begin
        cmd.op    = OP_MRD_L;
        state_nxt = S_QSZ;
      end
      S_QSZ: begin
        cmd.op    = OP_QSZ;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/fsrl_dp.sv
`timescale 1ns / 1ps
module fsrl_dp import fsrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_item,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_item_t             out_item
);

  function automatic mean_t to_mean(pix_t p);
    return mean_t'(p) << MEAN_FRAC_BITS;
  endfunction

  function automatic label_t clamp_lab(label_t x, label_t h);
    return (x > h) ? h : x;
  endfunction

  function automatic sq_t sq_of(mean_t p, mean_t m);
    logic signed [MEAN_W:0]     d;
    logic signed [2*MEAN_W+1:0] p2;
    d  = $signed({1'b0, p}) - $signed({1'b0, m});
    p2 = d * d;
    return p2[SQ_W-1:0];
  endfunction

  function automatic mean_t avg_of(mean_t a, mean_t b);
    logic [MEAN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MEAN_W:1];
  endfunction

  // control state
  thr_t   threshold_r;
  fw_t    frame_width_r;
  col_t   col_r;
  logic   first_row_r;
  label_t highest_r;
  label_t left_r;
  logic   out_valid_r;

  // payload
  logic      is_query_r;
  pix_t      red_r, green_r, blue_r;
  label_t    query_r;
  label_t    cur_r, start_r, l_r, t_r;
  means_t    mean_l_r, mean_t_r;
  count_t    cnt_l_r, cnt_t_r;
  sq_t       sq0_r, sq1_r, sq2_r;
  logic      near_l_r, near_t_r;
  label_t    res_lab_r;
  count_t    res_size_r;
  logic      res_ovf_r;
  out_item_t out_item_r;

  // memories
  label_t above_mem [MAX_WIDTH];
  means_t mean_mem  [MAX_LABELS];
  count_t count_mem [MAX_LABELS];
  link_t  link_mem  [MAX_LABELS];
  label_t above_q_r;
  means_t mean_q_r;
  count_t count_q_r;
  link_t  link_q_r;

  logic   above_re, above_we;
  col_t   above_ra;
  label_t above_wd;
  logic   mean_re, mean_we;
  label_t mean_ra, mean_wa;
  means_t mean_wd;
  logic   count_we;
  label_t count_wa;
  count_t count_wd;
  logic   link_re, link_we;
  label_t link_wa;
  link_t  link_wd;

  logic             fs_pix;
  means_t           px_m;
  fw_t              w_eff;
  logic             col_last;
  cmp_t             lim;
  logic             dist_near;
  logic             add_l, add_t, open_reg, merge;
  label_t           new_lab;
  logic             open_ovf;
  count_t           inc_l, inc_t, msum;
  logic [COUNT_W:0] msum_w;
  label_t           act_lab;
  count_t           act_size;
  logic             book;
  label_t           book_lab;

  assign fs_pix   = !in_item.cmd && in_item.frame_start;
  assign px_m     = '{r: to_mean(red_r), g: to_mean(green_r), b: to_mean(blue_r)};
  assign w_eff    = (frame_width_r == '0) ? fw_t'(1) :
                    (frame_width_r > fw_t'(MAX_WIDTH)) ? fw_t'(MAX_WIDTH) : frame_width_r;
  assign col_last = (fw_t'(col_r) + fw_t'(1)) >= w_eff;
  assign lim      = cmp_t'(threshold_r) << (2 * MEAN_FRAC_BITS);
  assign dist_near = (cmp_t'(sq0_r) + cmp_t'(sq1_r) + cmp_t'(sq2_r)) <= lim;

  assign add_l    = near_l_r && (!near_t_r || (l_r == t_r));
  assign add_t    = !near_l_r && near_t_r;
  assign open_reg = !near_l_r && !near_t_r;
  assign merge    = near_l_r && near_t_r && (l_r != t_r);
  assign open_ovf = (highest_r == LABEL_MAX);
  assign new_lab  = open_ovf ? LABEL_MAX : label_t'(highest_r + 1'b1);
  assign inc_l    = (cnt_l_r == COUNT_MAX) ? cnt_l_r : count_t'(cnt_l_r + 1'b1);
  assign inc_t    = (cnt_t_r == COUNT_MAX) ? cnt_t_r : count_t'(cnt_t_r + 1'b1);
  assign msum_w   = {1'b0, cnt_l_r} + {1'b0, cnt_t_r} + 1'b1;
  assign msum     = (msum_w > {1'b0, COUNT_MAX}) ? COUNT_MAX : msum_w[COUNT_W-1:0];
  assign act_lab  = (add_l || merge) ? l_r : (add_t ? t_r : new_lab);
  assign act_size = add_l ? inc_l : (add_t ? inc_t : (merge ? msum : count_t'(1)));
  assign book     = (cmd.op == OP_INIT0) || (cmd.op == OP_ACT);
  assign book_lab = (cmd.op == OP_INIT0) ? '0 : act_lab;

  assign above_ra = fs_pix ? '0 : col_r;
  assign above_we = book;
  assign above_wd = book_lab;

  always_comb begin
    above_re = 1'b0;
    mean_re  = 1'b0;
    mean_ra  = l_r;
    mean_we  = 1'b0;
    mean_wa  = '0;
    mean_wd  = px_m;
    count_we = 1'b0;
    count_wa = '0;
    count_wd = count_t'(1);
    link_re  = 1'b0;
    link_we  = 1'b0;
    link_wa  = '0;
    link_wd  = '0;
    case (cmd.op)
      OP_ACCEPT: above_re = 1'b1;
      OP_INIT0: begin
        mean_we  = 1'b1;
        count_we = 1'b1;
        link_we  = 1'b1;
      end
      OP_LINK_RD: link_re = 1'b1;
      OP_ROOT_L, OP_ROOT_T, OP_ROOT_Q: begin
        link_we = (cur_r != start_r);
        link_wa = start_r;
        link_wd = '{valid: 1'b1, lab: cur_r};
      end
      OP_MRD_L: mean_re = 1'b1;
      OP_MRD_T: begin
        mean_re = 1'b1;
        mean_ra = t_r;
      end
      OP_ACT: begin
        if (open_reg) begin
          mean_we  = 1'b1;
          mean_wa  = new_lab;
          count_we = 1'b1;
          count_wa = new_lab;
          link_we  = 1'b1;
          link_wa  = new_lab;
        end else if (merge) begin
          mean_we  = 1'b1;
          mean_wa  = l_r;
          mean_wd  = '{r: avg_of(mean_l_r.r, mean_t_r.r),
                       g: avg_of(mean_l_r.g, mean_t_r.g),
                       b: avg_of(mean_l_r.b, mean_t_r.b)};
          count_we = 1'b1;
          count_wa = l_r;
          count_wd = msum;
          link_we  = 1'b1;
          link_wa  = t_r;
          link_wd  = '{valid: 1'b1, lab: l_r};
        end else begin
          count_we = 1'b1;
          count_wa = add_l ? l_r : t_r;
          count_wd = add_l ? inc_l : inc_t;
        end
      end
      OP_CLR_T: begin
        count_we = 1'b1;
        count_wa = t_r;
        count_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (above_we) above_mem[col_r] <= above_wd;
    if (above_re) above_q_r <= above_mem[above_ra];
  end

  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[mean_wa] <= mean_wd;
    if (mean_re) mean_q_r <= mean_mem[mean_ra];
  end

  always_ff @(posedge clk) begin
    if (count_we) count_mem[count_wa] <= count_wd;
    if (mean_re) count_q_r <= count_mem[mean_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_q_r <= link_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= thr_t'(400);
      frame_width_r <= fw_t'(640);
      col_r         <= '0;
      first_row_r   <= 1'b1;
      highest_r     <= '0;
      left_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD:   threshold_r   <= cfg_data;
          CFG_FRAME_WIDTH: frame_width_r <= cfg_data[FW_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_ACCEPT && fs_pix) begin
        col_r       <= '0;
        first_row_r <= 1'b1;
        highest_r   <= '0;
        left_r      <= '0;
      end
      if (cmd.op == OP_INIT0) highest_r <= '0;
      if (cmd.op == OP_ACT && open_reg && !open_ovf) highest_r <= new_lab;
      if (book) begin
        left_r <= book_lab;
        if (col_last) begin
          col_r       <= '0;
          first_row_r <= 1'b0;
        end else begin
          col_r <= col_t'(col_r + 1'b1);
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        is_query_r <= in_item.cmd;
        red_r      <= in_item.red;
        green_r    <= in_item.green;
        blue_r     <= in_item.blue;
        query_r    <= in_item.query_label;
      end
      OP_QOOR: begin
        res_lab_r  <= query_r;
        res_size_r <= '0;
        res_ovf_r  <= 1'b0;
      end
      OP_INIT0: begin
        res_lab_r  <= '0;
        res_size_r <= count_t'(1);
        res_ovf_r  <= 1'b0;
      end
      OP_RES_L: begin
        cur_r   <= clamp_lab((!first_row_r && col_r == '0) ? above_q_r : left_r, highest_r);
        start_r <= clamp_lab((!first_row_r && col_r == '0) ? above_q_r : left_r, highest_r);
      end
      OP_RES_T: begin
        cur_r   <= clamp_lab(above_q_r, highest_r);
        start_r <= clamp_lab(above_q_r, highest_r);
      end
      OP_RES_Q: begin
        cur_r   <= query_r;
        start_r <= query_r;
      end
      OP_STEP: cur_r <= link_q_r.lab;
      OP_ROOT_L: begin
        l_r <= cur_r;
        t_r <= cur_r;
      end
      OP_ROOT_T: t_r <= cur_r;
      OP_ROOT_Q: l_r <= cur_r;
      OP_MRD_T: begin
        mean_l_r <= mean_q_r;
        cnt_l_r  <= count_q_r;
        sq0_r    <= sq_of(px_m.r, mean_q_r.r);
        sq1_r    <= sq_of(px_m.g, mean_q_r.g);
        sq2_r    <= sq_of(px_m.b, mean_q_r.b);
      end
      OP_CAP_T: begin
        mean_t_r <= mean_q_r;
        cnt_t_r  <= count_q_r;
        sq0_r    <= sq_of(px_m.r, mean_q_r.r);
        sq1_r    <= sq_of(px_m.g, mean_q_r.g);
        sq2_r    <= sq_of(px_m.b, mean_q_r.b);
        near_l_r <= dist_near;
      end
      OP_NEAR_T: near_t_r <= dist_near;
      OP_ACT: begin
        res_lab_r  <= act_lab;
        res_size_r <= act_size;
        res_ovf_r  <= open_reg && open_ovf;
      end
      OP_QSZ: begin
        res_lab_r  <= l_r;
        res_size_r <= count_q_r;
        res_ovf_r  <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_item_r <= '{label: res_lab_r, region_size: res_size_r, overflow: res_ovf_r};
    end
  end

  assign stat.is_query   = is_query_r;
  assign stat.q_oor      = query_r > highest_r;
  assign stat.first_pix  = first_row_r && (col_r == '0);
  assign stat.two_nbr    = !first_row_r && (col_r != '0);
  assign stat.link_valid = link_q_r.valid;
  assign stat.merge      = merge;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
